>>> src/mbp_pkg.sv
// Package for the MSB-first bit packer: widths, action codes and the
// command/status structs between controller and datapath. No dependencies.
package mbp_pkg;

    localparam int MAX_CODE_BITS = 64;
    localparam int BYTE_BITS     = 8;
    localparam int LEN_W         = 7;
    localparam int CNT_W         = 3;
    localparam int WIN_BITS      = MAX_CODE_BITS + BYTE_BITS;
    localparam int NBYTE_W       = 4;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_FLUSH  = 1'b1;

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_has_bytes;
        logic last_byte;
    } t_status;

endpackage

>>> src/mbp_ifs.sv
// Channel interfaces of the bit packer: code words in, byte words out.
// Depends on mbp_pkg.
interface mbp_code_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [mbp_pkg::MAX_CODE_BITS-1:0]   code_value;
    logic [mbp_pkg::LEN_W-1:0]           code_length;

    modport source (output valid, action, code_value, code_length, input ready);
    modport sink   (input valid, action, code_value, code_length, output ready);
endinterface

interface mbp_byte_if;
    logic                            valid;
    logic                            ready;
    logic [mbp_pkg::BYTE_BITS-1:0]   out_byte;
    logic                            last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

>>> src/msb_first_bit_packer_unit.sv
// Top level of the MSB-first bit packer: joins controller and datapath to
// the code and byte channels. Depends on mbp_pkg, mbp_ifs, mbp_ctrl, mbp_dpath.
//
// Packs right-aligned codes of 0 to 64 bits (longer lengths saturate to 64)
// into bytes, earliest bit in bit 7, and marks the last byte of each word
// with last. A flush word emits the pending partial byte, zero padded, if
// any, and clears it. A code word that completes no byte, and a flush with
// nothing pending, leave the controller idle, so such words stream one per
// cycle. A word that completes k bytes (1 to 8) is first aligned into the
// 72-bit byte window, then shifted out a byte at a time through the output
// byte register, which drains at most one byte per cycle and holds while
// the sink stalls; the next word is taken only after its last byte.
module msb_first_bit_packer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbp_code_if.sink     i_code,
    mbp_byte_if.source   o_byte
);
    import mbp_pkg::*;

    t_cmd    cmd;
    t_status status;

    mbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_code.valid),
        .o_in_ready  (i_code.ready),
        .i_out_ready (o_byte.ready),
        .o_out_valid (o_byte.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mbp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (i_code.action),
        .i_code_value  (i_code.code_value),
        .i_code_length (i_code.code_length),
        .o_out_byte    (o_byte.out_byte),
        .o_last        (o_byte.last)
    );

endmodule

>>> src/mbp_ctrl.sv
// Controller of the bit packer: accept/drain state machine and the output
// valid flag. Depends on mbp_pkg.
module mbp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  mbp_pkg::t_status  i_status,
    output mbp_pkg::t_cmd     o_cmd
);
    import mbp_pkg::*;

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic slot_free;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.in_has_bytes) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> src/mbp_dpath.sv
// Datapath of the bit packer: code alignment, byte window, pending partial
// byte and output byte register. Depends on mbp_pkg.
module mbp_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mbp_pkg::t_cmd                      i_cmd,
    output mbp_pkg::t_status                   o_status,
    input  logic                               i_action,
    input  logic [mbp_pkg::MAX_CODE_BITS-1:0]  i_code_value,
    input  logic [mbp_pkg::LEN_W-1:0]          i_code_length,
    output logic [mbp_pkg::BYTE_BITS-1:0]      o_out_byte,
    output logic                               o_last
);
    import mbp_pkg::*;

    logic [WIN_BITS-1:0]      r_window;
    logic [WIN_BITS-1:0]      n_window;
    logic [NBYTE_W-1:0]       r_left;
    logic [NBYTE_W-1:0]       n_left;
    logic [BYTE_BITS-1:0]     r_pend_bits;
    logic [BYTE_BITS-1:0]     n_pend_bits;
    logic [CNT_W-1:0]         r_pend_cnt;
    logic [CNT_W-1:0]         n_pend_cnt;
    logic [BYTE_BITS-1:0]     r_out_byte;
    logic                     r_out_last;

    logic [LEN_W-1:0]         len_sat;
    logic [MAX_CODE_BITS-1:0] code_left;
    logic [WIN_BITS-1:0]      app_window;
    logic [LEN_W-1:0]         total;
    logic [NBYTE_W-1:0]       app_nbytes;
    logic [WIN_BITS-1:0]      rest;
    logic [NBYTE_W-1:0]       in_nbytes;

    always_comb begin
        len_sat    = (i_code_length > LEN_W'(MAX_CODE_BITS))
                   ? LEN_W'(MAX_CODE_BITS) : i_code_length;
        code_left  = i_code_value << (LEN_W'(MAX_CODE_BITS) - len_sat);
        app_window = {r_pend_bits, {MAX_CODE_BITS{1'b0}}}
                   | ({code_left, {BYTE_BITS{1'b0}}} >> r_pend_cnt);
        total      = len_sat + LEN_W'(r_pend_cnt);
        app_nbytes = total[LEN_W-1:CNT_W];
        rest       = app_window << {app_nbytes, 3'b000};
        in_nbytes  = (i_action == ACT_FLUSH)
                   ? NBYTE_W'(r_pend_cnt != '0) : app_nbytes;
    end

    assign o_status.in_has_bytes = (in_nbytes != '0);
    assign o_status.last_byte    = (r_left == NBYTE_W'(1));

    always_comb begin
        n_window    = r_window;
        n_left      = r_left;
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        if (i_cmd.load) begin
            n_left = in_nbytes;
            if (i_action == ACT_FLUSH) begin
                n_window    = {r_pend_bits, {MAX_CODE_BITS{1'b0}}};
                n_pend_bits = '0;
                n_pend_cnt  = '0;
            end else begin
                n_window    = app_window;
                n_pend_bits = rest[WIN_BITS-1 -: BYTE_BITS];
                n_pend_cnt  = total[CNT_W-1:0];
            end
        end else if (i_cmd.emit) begin
            n_window = r_window << BYTE_BITS;
            n_left   = r_left - NBYTE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            r_left      <= n_left;
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
        if (i_cmd.emit) begin
            r_out_byte <= r_window[WIN_BITS-1 -: BYTE_BITS];
            r_out_last <= (r_left == NBYTE_W'(1));
        end
    end

    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last;

    a_emit_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_left != '0))
        else $error("byte emitted with none left");

    a_load_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_left == '0) && !i_cmd.emit)
        else $error("word loaded while bytes remain");

    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_cnt == '0) |-> (r_pend_bits == '0))
        else $error("pending bits set with zero count");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && (i_action == ACT_FLUSH) |=> (r_pend_cnt == '0))
        else $error("flush left pending bits");

endmodule
